@@ src/lir_pkg.sv @@
// Shared types and constants for the linear interpolation resampler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package lir_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int NARROW_W      = 16;
  localparam int STEP_W        = 23;
  localparam int CH_W          = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_CHANNELS  = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET     = 23'd65536;
  localparam logic [CH_W-1:0]   CHANNELS_RESET = 2'd2;

  // Settings the front end needs to classify a frame.
  typedef struct packed {
    logic wide;
    logic stereo;
  } front_cfg_t;

  // One classified frame, handed from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur_left;
    logic signed [SAMPLE_W-1:0] cur_right;
    logic signed [SAMPLE_W-1:0] prev_left;
    logic signed [SAMPLE_W-1:0] prev_right;
    logic                       interp;
    logic                       eos;
    logic                       stereo;
  } job_t;

endpackage
`default_nettype wire

@@ src/lir_front.sv @@
// Front end: takes input frames, sign-extends and classifies them, and keeps
// the previous frame. Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lir_front
  import lir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire front_cfg_t          cfg,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [2*SAMPLE_W-1:0] in_tdata,
  input  wire logic                in_tlast,
  input  wire logic                q_full,
  output logic                     push,
  output job_t                     push_job
);

  logic signed [SAMPLE_W-1:0] prev_left_r, prev_left_nxt;
  logic signed [SAMPLE_W-1:0] prev_right_r, prev_right_nxt;
  logic                       prev_valid_r, prev_valid_nxt;
  logic signed [SAMPLE_W-1:0] cur_left, cur_right;
  logic [SAMPLE_W-1:0]        raw_left, raw_right;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign raw_left  = in_tdata[SAMPLE_W-1:0];
  assign raw_right = in_tdata[2*SAMPLE_W-1:SAMPLE_W];

  // Narrow mode uses only the low half of each sample, sign-extended.
  always_comb begin
    if (cfg.wide) begin
      cur_left  = $signed(raw_left);
      cur_right = $signed(raw_right);
    end else begin
      cur_left  = $signed({{(SAMPLE_W-NARROW_W){raw_left[NARROW_W-1]}},
                           raw_left[NARROW_W-1:0]});
      cur_right = $signed({{(SAMPLE_W-NARROW_W){raw_right[NARROW_W-1]}},
                           raw_right[NARROW_W-1:0]});
    end
    if (!cfg.stereo) begin
      cur_right = '0;
    end
  end

  // Build the request for the back end.
  always_comb begin
    push_job.cur_left   = cur_left;
    push_job.cur_right  = cur_right;
    push_job.prev_left  = prev_left_r;
    push_job.prev_right = prev_right_r;
    push_job.interp     = prev_valid_r;
    push_job.eos        = in_tlast;
    push_job.stereo     = cfg.stereo;
  end

  // An end-of-stream frame forgets the previous frame.
  always_comb begin
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    prev_valid_nxt = prev_valid_r;
    if (push) begin
      if (in_tlast) begin
        prev_left_nxt  = '0;
        prev_right_nxt = '0;
        prev_valid_nxt = 1'b0;
      end else begin
        prev_left_nxt  = cur_left;
        prev_right_nxt = cur_right;
        prev_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/lir_queue.sv @@
// Short first-in first-out queue of classified frames between front and back.
// Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lir_queue
  import lir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; the count says what is valid.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ src/lir_back.sv @@
// Back end: owns the phase, walks the outputs of one frame at a time and
// holds each result until it is taken. Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lir_back
  import lir_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [STEP_W-1:0]     phase_step,
  input  wire logic                  q_empty,
  input  wire job_t                  q_job,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*SAMPLE_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  localparam int PH_W   = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam logic [PH_W-1:0] ONE      = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0] MIN_STEP = ONE >> 2;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EVAL = 2'd1;
  localparam logic [1:0] B_SUM  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  job_t                       job_r, job_nxt;
  logic signed [DIFF_W-1:0]   diff_left_r, diff_left_nxt;
  logic signed [DIFF_W-1:0]   diff_right_r, diff_right_nxt;
  logic signed [PROD_W-1:0]   prod_left_r, prod_left_nxt;
  logic signed [PROD_W-1:0]   prod_right_r, prod_right_nxt;
  logic signed [SAMPLE_W-1:0] out_left_r, out_left_nxt;
  logic signed [SAMPLE_W-1:0] out_right_r, out_right_nxt;
  logic                       last_r, last_nxt;

  logic [PH_W-1:0]            step_ext, step_eff, nphase, nphase_m1;
  logic signed [FRAC_BITS:0]  frac;
  logic signed [PROD_W-1:0]   shift_left, shift_right;
  logic                       last_interp, last_copy;

  // Steps below a quarter frame are raised to a quarter frame.
  assign step_ext  = PH_W'(phase_step);
  assign step_eff  = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
  assign nphase    = phase_r + step_eff;
  assign nphase_m1 = nphase - ONE;

  // An interpolated output is the last of its frame unless another phase
  // follows in this interval or the end-of-stream copies add more.
  assign last_interp = (nphase >= ONE) && !(job_r.eos && (nphase_m1 < ONE));
  assign last_copy   = (nphase >= ONE);

  // Full-width products; registered before the final add.
  assign frac           = $signed({1'b0, phase_r[FRAC_BITS-1:0]});
  assign prod_left_nxt  = diff_left_r * frac;
  assign prod_right_nxt = diff_right_r * frac;
  assign shift_left     = prod_left_r >>> FRAC_BITS;
  assign shift_right    = prod_right_r >>> FRAC_BITS;

  assign pop        = (state_r == B_IDLE) && !q_empty;
  assign out_tvalid = (state_r == B_OUT);
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = last_r;

  // Output sequencer.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    job_nxt        = job_r;
    diff_left_nxt  = diff_left_r;
    diff_right_nxt = diff_right_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    last_nxt       = last_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_nxt        = q_job;
          diff_left_nxt  = $signed({q_job.cur_left[SAMPLE_W-1], q_job.cur_left})
                         - $signed({q_job.prev_left[SAMPLE_W-1], q_job.prev_left});
          diff_right_nxt = $signed({q_job.cur_right[SAMPLE_W-1], q_job.cur_right})
                         - $signed({q_job.prev_right[SAMPLE_W-1], q_job.prev_right});
          state_nxt      = B_EVAL;
        end
      end
      B_EVAL: begin
        if (job_r.interp) begin
          if (phase_r < ONE) begin
            // Products are taken this cycle with the current phase.
            last_nxt  = last_interp;
            phase_nxt = nphase;
            state_nxt = B_SUM;
          end else begin
            phase_nxt = phase_r - ONE;
            if (job_r.eos) begin
              job_nxt.interp = 1'b0;
            end else begin
              state_nxt = B_IDLE;
            end
          end
        end else if (job_r.eos && (phase_r < ONE)) begin
          // End-of-stream copies of the current frame.
          out_left_nxt  = job_r.cur_left;
          out_right_nxt = job_r.cur_right;
          last_nxt      = last_copy;
          phase_nxt     = nphase;
          state_nxt     = B_OUT;
        end else begin
          if (job_r.eos) begin
            phase_nxt = '0;
          end
          state_nxt = B_IDLE;
        end
      end
      B_SUM: begin
        out_left_nxt = job_r.prev_left + shift_left[SAMPLE_W-1:0];
        if (job_r.stereo) begin
          out_right_nxt = job_r.prev_right + shift_right[SAMPLE_W-1:0];
        end else begin
          out_right_nxt = '0;
        end
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_tready) begin
          state_nxt = B_EVAL;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    diff_left_r  <= diff_left_nxt;
    diff_right_r <= diff_right_nxt;
    prod_left_r  <= prod_left_nxt;
    prod_right_r <= prod_right_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
    last_r       <= last_nxt;
  end

endmodule
`default_nettype wire

@@ src/linear_interp_resampler.sv @@
// Linear interpolation resampler: each interpolated output of a frame passes
// through the output sequencer's evaluate, sum and output states in turn;
// end-of-stream copies go from evaluate straight to output.
// A two-entry queue lets frames be taken while a result waits.
// Synchronous active-low reset clears the phase, previous frame and queue.
`timescale 1ns / 1ps
`default_nettype none
module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // sample_left [31:0], sample_right [63:32]
  input  wire logic [2*SAMPLE_W-1:0]  in_tdata,
  // end_of_stream
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_left [31:0], out_right [63:32]
  output logic [2*SAMPLE_W-1:0]       out_tdata,
  // last_of_run
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [STEP_W-1:0]      cfg_data
);

  logic [STEP_W-1:0] phase_step_r;
  logic              wide_r;
  logic [CH_W-1:0]   channels_r;
  front_cfg_t        front_cfg;
  logic              push, q_full, q_empty, pop;
  job_t              push_job, pop_job;

  assign cfg_ready        = 1'b1;
  assign front_cfg.wide   = wide_r;
  assign front_cfg.stereo = (channels_r >= 2'd2) && (MAX_CHANNELS >= 2);

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
      wide_r       <= 1'b0;
      channels_r   <= CHANNELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:    phase_step_r <= cfg_data;
        REG_WIDE_SAMPLES:  wide_r       <= cfg_data[0];
        REG_CHANNELS_USED: channels_r   <= cfg_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (front_cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  lir_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  lir_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ src/lir_checker.sv @@
// Port-level checks for the resampler, bound to the top level.
// Depends on lir_pkg and linear_interp_resampler.
`timescale 1ns / 1ps
`default_nettype none
module lir_checker
  import lir_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [2*SAMPLE_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // Reset empties the queue, so a frame can be taken at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // Every result is followed by a fresh pass through evaluation before the next one.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("results offered in adjacent cycles");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);
`default_nettype wire
